FILE: rtl/sbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack bytecode executor package
// Field types, opcode and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbe_pkg;

    // Widths of the item fields on the two channels.
    localparam int OP_W     = 4;
    localparam int IMM_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int PRINT_W  = 32;
    localparam int DEPTH_W  = 7;

    // Number of distinct codes that the slot field can carry.
    localparam int SLOT_CODES = 2 ** SLOT_W;

    // Width of the multiplier digit that the iterative multiplier handles per step.
    localparam int MUL_DIGIT_W = 16;

    typedef logic        [OP_W-1:0]     op_t;
    typedef logic signed [IMM_W-1:0]    imm_t;
    typedef logic        [SLOT_W-1:0]   slot_t;
    typedef logic        [STATUS_W-1:0] status_t;
    typedef logic signed [PRINT_W-1:0]  print_t;
    typedef logic        [DEPTH_W-1:0]  depth_t;

    // Opcodes.
    localparam op_t OP_PUSH  = 4'd0;
    localparam op_t OP_ADD   = 4'd1;
    localparam op_t OP_SUB   = 4'd2;
    localparam op_t OP_MUL   = 4'd3;
    localparam op_t OP_DIV   = 4'd4;
    localparam op_t OP_SAVE  = 4'd5;
    localparam op_t OP_LOAD  = 4'd6;
    localparam op_t OP_EMIT  = 4'd7;
    localparam op_t OP_HALT  = 4'd8;

    // Result status codes.
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_PRINTED   = 3'd1;
    localparam status_t ST_HALTED    = 3'd2;
    localparam status_t ST_UNDERFLOW = 3'd3;
    localparam status_t ST_OVERFLOW  = 3'd4;
    localparam status_t ST_DIV_ZERO  = 3'd5;
    localparam status_t ST_UNKNOWN   = 3'd6;
    localparam status_t ST_IGNORED   = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;  // write one zero into the variable file
        logic load;        // capture the incoming item and start the memory reads
        logic calc_start;  // launch the iterative multiply or divide
        logic commit;      // apply the item's effects and load the result register
    } sbe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // the clearing pass is at its last slot
        logic need_calc;   // the captured item needs the multiply or divide unit
        logic calc_done;   // the multiply or divide unit holds its result
        logic out_free;    // the result register can take a new item
    } sbe_sts_t;

endpackage
`default_nettype wire

FILE: rtl/sbe_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack bytecode executor channels
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------

// Instruction channel.
interface sbe_instr_if;
    logic                 valid;
    logic                 ready;
    sbe_pkg::op_t         op;
    sbe_pkg::imm_t        immediate;
    sbe_pkg::slot_t       slot;

    modport source (output valid, output op, output immediate, output slot, input ready);
    modport sink   (input valid, input op, input immediate, input slot, output ready);
endinterface

// Result channel.
interface sbe_result_if;
    logic                 valid;
    logic                 ready;
    sbe_pkg::status_t     status;
    sbe_pkg::print_t      print_value;
    sbe_pkg::depth_t      stack_depth;

    modport source (output valid, output status, output print_value, output stack_depth,
                    input ready);
    modport sink   (input valid, input status, input print_value, input stack_depth,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/stack_bytecode_executor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack bytecode executor
// Executes one stack-machine instruction per item and returns one result item.
// ----------------------------------------------------------------------------
// After reset the block zeroes the variable file slot by slot and
// holds instr.ready low meanwhile. It then works on one item at a time: push,
// load, add, sub, store, print, halt, unknown opcodes and every item that ends
// in an error pass from acceptance to the result register through the
// registered read of the stack and variable RAMs and then the execute step.
// Mul and div go on from the execute step to the iterative unit, which takes
// one 16-bit digit of the multiplier or one quotient bit per cycle. The result
// register lets the next item be accepted while the previous result waits; a
// result that is not taken stalls the next one at its execute step. After halt
// every item answers "ignored" until reset.
module stack_bytecode_executor #(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_SLOTS   = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    sbe_instr_if.sink      instr,
    sbe_result_if.source   result
);

    sbe_pkg::sbe_cmd_t cmd;
    sbe_pkg::sbe_sts_t sts;

    sbe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_valid (instr.valid),
        .instr_ready (instr.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    sbe_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VAR_SLOTS   (VAR_SLOTS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .op           (instr.op),
        .immediate    (instr.immediate),
        .slot         (instr.slot),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .status       (result.status),
        .print_value  (result.print_value),
        .stack_depth  (result.stack_depth)
    );

`ifndef ASSERT_OFF
    // A commit never overwrites a result that is still waiting.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("result register overwritten before it was taken");

    // Only a print carries a value.
    a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != sbe_pkg::ST_PRINTED)) |->
        (result.print_value == '0))
        else $error("print value set on a non-print result");

    // An overflow is reported only with a full stack.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == sbe_pkg::ST_OVERFLOW)) |->
        (result.stack_depth == sbe_pkg::depth_t'(STACK_DEPTH)))
        else $error("overflow reported below full depth");

    // No item is taken while the variable file is being cleared.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !instr.ready)
        else $error("item accepted during the clearing pass");
`endif

endmodule
`default_nettype wire

FILE: rtl/sbe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/sbe_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative multiply and divide unit
// Multiplies one digit of the multiplier per cycle, and divides by restoring
// division on magnitudes, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sbe_muldiv #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  is_div,
    input  wire logic [DATA_WIDTH-1:0] a,
    input  wire logic [DATA_WIDTH-1:0] b,
    output logic                       done,
    output logic      [DATA_WIDTH-1:0] result
);

    localparam int DW     = DATA_WIDTH;
    localparam int MD     = (DW < sbe_pkg::MUL_DIGIT_W) ? DW : sbe_pkg::MUL_DIGIT_W;
    localparam int MSTEPS = (DW + MD - 1) / MD;
    localparam int CNTW   = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            div_reg, div_next;
    logic            neg_reg, neg_next;
    logic [DW-1:0]   x_reg, x_next;
    logic [DW-1:0]   y_reg, y_next;
    logic [DW:0]     acc_reg, acc_next;

    logic [DW-1:0]    a_mag, b_mag;
    logic [DW+MD-1:0] prod;
    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;

    // Operand magnitudes; the most negative value maps onto its own bit pattern.
    assign a_mag = a[DW-1] ? (~a + DW'(1)) : a;
    assign b_mag = b[DW-1] ? (~b + DW'(1)) : b;

    // One partial product and one trial subtraction per cycle.
    assign prod   = x_reg * y_reg[MD-1:0];
    assign rem_sh = {acc_reg[DW-1:0], x_reg[DW-1]};
    assign diff   = rem_sh - {1'b0, y_reg};

    // Step sequencing.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            div_next  = is_div;
            neg_next  = a[DW-1] ^ b[DW-1];
            acc_next  = '0;
            if (is_div)
            begin
                x_next   = a_mag;
                y_next   = b_mag;
                cnt_next = CNTW'(DW);
            end
            else
            begin
                x_next   = a;
                y_next   = b;
                cnt_next = CNTW'(MSTEPS);
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (div_reg)
            begin
                // Restoring division: keep the difference when it does not go negative.
                if (!diff[DW])
                begin
                    acc_next = diff;
                end
                else
                begin
                    acc_next = rem_sh;
                end
                x_next = {x_reg[DW-2:0], ~diff[DW]};
            end
            else
            begin
                // Shift-and-add by digits, keeping only the low word.
                acc_next = {1'b0, acc_reg[DW-1:0] + prod[DW-1:0]};
                x_next   = x_reg << MD;
                y_next   = y_reg >> MD;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    // The quotient takes the sign of the operands; the product is the low word.
    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (~x_reg + DW'(1)) : x_reg) : acc_reg[DW-1:0];

endmodule
`default_nettype wire

FILE: rtl/sbe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack bytecode executor datapath
// Operand stack with the top entry in a register and the rest in a RAM,
// variable file RAM, status decode, multiply/divide unit and result register.
// ----------------------------------------------------------------------------
module sbe_datapath #(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_SLOTS   = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sbe_pkg::sbe_cmd_t cmd,
    output sbe_pkg::sbe_sts_t      sts,
    input  wire sbe_pkg::op_t      op,
    input  wire sbe_pkg::imm_t     immediate,
    input  wire sbe_pkg::slot_t    slot,
    input  wire logic              result_ready,
    output logic                   result_valid,
    output sbe_pkg::status_t       status,
    output sbe_pkg::print_t        print_value,
    output sbe_pkg::depth_t        stack_depth
);

    localparam int DW  = DATA_WIDTH;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int VSW = $clog2(VAR_SLOTS);
    localparam int CW  = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0]    count_reg, count_next;
    logic [DW-1:0]    tos_reg, tos_next;
    logic             halted_reg, halted_next;
    logic [VSW-1:0]   clr_reg;
    sbe_pkg::op_t     op_reg;
    logic [DW-1:0]    imm_reg;
    logic [VSW-1:0]   slot_reg;

    logic             out_valid_reg;
    sbe_pkg::status_t status_reg;
    sbe_pkg::print_t  print_reg;
    sbe_pkg::depth_t  depth_reg;

    logic [VSW-1:0]   slot_mod;
    logic [CW-1:0]    stk_raddr_full, stk_waddr_full;
    logic             stk_we, var_we;
    logic [DW-1:0]    stk_rd, var_rd;
    logic [VSW-1:0]   var_waddr;
    logic [DW-1:0]    var_wdata;
    logic             md_done;
    logic [DW-1:0]    md_result;

    sbe_pkg::status_t exe_status;
    logic             apply;
    logic             has_two, has_one, is_full;

    // Slot index folded into the variable file, as a table over the slot codes.
    always_comb
    begin
        slot_mod = '0;
        for (int i = 0; i < sbe_pkg::SLOT_CODES; i++)
        begin
            if (slot == sbe_pkg::SLOT_W'(i))
            begin
                slot_mod = VSW'(i % VAR_SLOTS);
            end
        end
    end

    // The RAM holds every stack entry below the top one.
    assign stk_raddr_full = count_reg - CW'(2);
    assign stk_waddr_full = count_reg - CW'(1);

    sbe_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr_full[SAW-1:0]),
        .wdata (tos_reg),
        .re    (cmd.load),
        .raddr (stk_raddr_full[SAW-1:0]),
        .rdata (stk_rd)
    );

    // Variable file; the clearing pass owns the write port after reset.
    assign var_waddr = cmd.clear_step ? clr_reg : slot_reg;
    assign var_wdata = cmd.clear_step ? '0 : tos_reg;

    sbe_ram #(
        .WIDTH (DW),
        .DEPTH (VAR_SLOTS)
    ) u_var_ram (
        .clk   (clk),
        .we    (cmd.clear_step | var_we),
        .waddr (var_waddr),
        .wdata (var_wdata),
        .re    (cmd.load),
        .raddr (slot_mod),
        .rdata (var_rd)
    );

    sbe_muldiv #(
        .DATA_WIDTH (DW)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.calc_start),
        .is_div (op_reg == sbe_pkg::OP_DIV),
        .a      (stk_rd),
        .b      (tos_reg),
        .done   (md_done),
        .result (md_result)
    );

    // Status of the captured item, checked before any state changes.
    assign has_two = count_reg >= CW'(2);
    assign has_one = count_reg != '0;
    assign is_full = count_reg >= CW'(STACK_DEPTH);

    always_comb
    begin
        exe_status = sbe_pkg::ST_OK;
        if (halted_reg)
        begin
            exe_status = sbe_pkg::ST_IGNORED;
        end
        else
        begin
            case (op_reg)
                sbe_pkg::OP_PUSH, sbe_pkg::OP_LOAD:
                begin
                    if (is_full)
                    begin
                        exe_status = sbe_pkg::ST_OVERFLOW;
                    end
                end
                sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL:
                begin
                    if (!has_two)
                    begin
                        exe_status = sbe_pkg::ST_UNDERFLOW;
                    end
                end
                sbe_pkg::OP_DIV:
                begin
                    if (!has_two)
                    begin
                        exe_status = sbe_pkg::ST_UNDERFLOW;
                    end
                    else if (tos_reg == '0)
                    begin
                        exe_status = sbe_pkg::ST_DIV_ZERO;
                    end
                end
                sbe_pkg::OP_SAVE:
                begin
                    if (!has_one)
                    begin
                        exe_status = sbe_pkg::ST_UNDERFLOW;
                    end
                end
                sbe_pkg::OP_EMIT:
                begin
                    if (!has_one)
                    begin
                        exe_status = sbe_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        exe_status = sbe_pkg::ST_PRINTED;
                    end
                end
                sbe_pkg::OP_HALT:
                begin
                    exe_status = sbe_pkg::ST_HALTED;
                end
                default:
                begin
                    exe_status = sbe_pkg::ST_UNKNOWN;
                end
            endcase
        end
    end

    assign apply = exe_status inside {sbe_pkg::ST_OK, sbe_pkg::ST_PRINTED, sbe_pkg::ST_HALTED};

    // Effects of a committed item on the stack, the variable file and the halt flag.
    always_comb
    begin
        tos_next    = tos_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        stk_we      = 1'b0;
        var_we      = 1'b0;
        if (cmd.commit && apply)
        begin
            case (op_reg)
                sbe_pkg::OP_PUSH, sbe_pkg::OP_LOAD:
                begin
                    stk_we     = has_one;
                    tos_next   = (op_reg == sbe_pkg::OP_PUSH) ? imm_reg : var_rd;
                    count_next = count_reg + CW'(1);
                end
                sbe_pkg::OP_ADD:
                begin
                    tos_next   = stk_rd + tos_reg;
                    count_next = count_reg - CW'(1);
                end
                sbe_pkg::OP_SUB:
                begin
                    tos_next   = stk_rd - tos_reg;
                    count_next = count_reg - CW'(1);
                end
                sbe_pkg::OP_MUL, sbe_pkg::OP_DIV:
                begin
                    tos_next   = md_result;
                    count_next = count_reg - CW'(1);
                end
                sbe_pkg::OP_SAVE, sbe_pkg::OP_EMIT:
                begin
                    var_we     = (op_reg == sbe_pkg::OP_SAVE);
                    tos_next   = stk_rd;
                    count_next = count_reg - CW'(1);
                end
                sbe_pkg::OP_HALT:
                begin
                    halted_next = 1'b1;
                end
                default:
                begin
                    tos_next = tos_reg;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            halted_reg <= halted_next;
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + VSW'(1);
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Top of stack, captured item and result payload.
    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (cmd.load)
        begin
            op_reg   <= op;
            imm_reg  <= DW'(immediate);
            slot_reg <= slot_mod;
        end
        if (cmd.commit)
        begin
            status_reg <= exe_status;
            print_reg  <= (exe_status == sbe_pkg::ST_PRINTED) ?
                          sbe_pkg::print_t'($signed(tos_reg)) : '0;
            depth_reg  <= sbe_pkg::depth_t'(count_next);
        end
    end

    // Status toward the controller.
    assign sts.clear_last = clr_reg == VSW'(VAR_SLOTS - 1);
    assign sts.need_calc  = (exe_status == sbe_pkg::ST_OK) &&
                            ((op_reg == sbe_pkg::OP_MUL) || (op_reg == sbe_pkg::OP_DIV));
    assign sts.calc_done  = md_done;
    assign sts.out_free   = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign print_value  = print_reg;
    assign stack_depth  = depth_reg;

endmodule
`default_nettype wire

FILE: rtl/sbe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack bytecode executor controller
// Sequences the clearing pass, item capture, execution, the wait for the
// multiply/divide unit, and the hand-off to the result register.
// ----------------------------------------------------------------------------
module sbe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              instr_valid,
    output logic                   instr_ready,
    input  wire sbe_pkg::sbe_sts_t sts,
    output sbe_pkg::sbe_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_CALC  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        instr_ready = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                instr_ready = 1'b1;
                if (instr_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.need_calc)
                begin
                    cmd.calc_start = 1'b1;
                    state_next     = S_CALC;
                end
                else if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CALC:
            begin
                if (sts.calc_done && sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: sim/tb_stack_bytecode_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack bytecode executor testbench
// Feeds instruction items through the valid/ready channel with random gaps,
// and stalls the result channel at random. A shadow stack machine predicts
// every result item, which is then checked field by field. The stimulus
// covers underflow, overflow, divide by zero, wrapping arithmetic and
// unknown opcodes, and ends with a halt followed by items that are ignored.
// ----------------------------------------------------------------------------
module tb_stack_bytecode_executor;

    localparam int STACK_ENTRIES  = 64;
    localparam int VAR_ENTRIES    = 64;
    localparam int PHASE_ITEMS    = 510;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // Bounds of the opcode range that carries no instruction.
    localparam sbe_pkg::op_t OP_FIRST_UNUSED = 4'd9;
    localparam sbe_pkg::op_t OP_LAST_UNUSED  = 4'd15;

    typedef struct {
        sbe_pkg::op_t   op;
        sbe_pkg::imm_t  immediate;
        sbe_pkg::slot_t slot;
    } instr_item_t;

    typedef struct {
        sbe_pkg::status_t status;
        sbe_pkg::print_t  print_value;
        sbe_pkg::depth_t  stack_depth;
    } result_item_t;

    logic clk;
    logic rst_n;

    sbe_instr_if  instr_ch ();
    sbe_result_if result_ch ();

    stack_bytecode_executor u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    // Instructions waiting to be issued and results waiting to arrive.
    instr_item_t  program_queue[$];
    result_item_t predicted_results[$];

    // Shadow machine state.
    logic [31:0] shadow_stack[STACK_ENTRIES];
    logic [31:0] shadow_vars[VAR_ENTRIES];
    int          shadow_depth;
    bit          shadow_halted;

    // Stack depth as the stimulus generator expects it to be.
    int plan_depth;

    bit quiet_phase;
    bit instr_taken;
    int issue_gap;
    int accept_stall;
    int error_count;
    int idle_cycles;

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Length of the next idle stretch: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic sbe_pkg::imm_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return sbe_pkg::imm_t'($urandom_range(0, 16)) - sbe_pkg::imm_t'(8);
        if (r < 35)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return sbe_pkg::imm_t'(-1);
                3: return '0;
                default: return sbe_pkg::imm_t'(1);
            endcase
        end
        return sbe_pkg::imm_t'($urandom());
    endfunction

    // Half of the slot picks fall on a few slots so that loads find stored values.
    function automatic sbe_pkg::slot_t pick_slot();
        if ($urandom_range(0, 1))
            return sbe_pkg::slot_t'($urandom_range(0, 7));
        return sbe_pkg::slot_t'($urandom_range(0, sbe_pkg::SLOT_CODES - 1));
    endfunction

    // Any opcode except halt, which is kept for the end of the run.
    function automatic sbe_pkg::op_t pick_live_op();
        int r;
        r = $urandom_range(0, 14);
        return sbe_pkg::op_t'((r >= int'(sbe_pkg::OP_HALT)) ? r + 1 : r);
    endfunction

    function automatic sbe_pkg::op_t pick_binary_op();
        case ($urandom_range(0, 3))
            0: return sbe_pkg::OP_ADD;
            1: return sbe_pkg::OP_SUB;
            2: return sbe_pkg::OP_MUL;
            default: return sbe_pkg::OP_DIV;
        endcase
    endfunction

    // Queue one instruction and track the stack depth it should leave.
    task automatic queue_instr(sbe_pkg::op_t op, sbe_pkg::imm_t value, sbe_pkg::slot_t slot);
        instr_item_t it;
        it.op        = op;
        it.immediate = value;
        it.slot      = slot;
        program_queue.push_back(it);
        case (op)
            sbe_pkg::OP_PUSH, sbe_pkg::OP_LOAD:
                if (plan_depth < STACK_ENTRIES)
                    plan_depth++;
            sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV:
                if (plan_depth >= 2)
                    plan_depth--;
            sbe_pkg::OP_SAVE, sbe_pkg::OP_EMIT:
                if (plan_depth >= 1)
                    plan_depth--;
            default: ;
        endcase
    endtask

    task automatic queue_operand();
        if ($urandom_range(0, 3) == 0)
            queue_instr(sbe_pkg::OP_LOAD, pick_value(), pick_slot());
        else
            queue_instr(sbe_pkg::OP_PUSH, pick_value(), pick_slot());
    endtask

    // Random program fragments until the phase holds enough items.
    task automatic queue_random_phase(int count);
        int stop_at;
        int n;
        int kind;
        stop_at = program_queue.size() + count;
        while (program_queue.size() < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                // Expression: operands, operators, then print or store.
                n = $urandom_range(2, 4);
                repeat (n)
                    queue_operand();
                repeat (n - 1)
                    queue_instr(pick_binary_op(), pick_value(), pick_slot());
                if ($urandom_range(0, 4) < 3)
                    queue_instr(sbe_pkg::OP_EMIT, pick_value(), pick_slot());
                else
                    queue_instr(sbe_pkg::OP_SAVE, pick_value(), pick_slot());
            end
            else if (kind < 76)
            begin
                // Round trip through a variable slot.
                n = pick_slot();
                queue_instr(sbe_pkg::OP_PUSH, pick_value(), sbe_pkg::slot_t'(n));
                queue_instr(sbe_pkg::OP_SAVE, pick_value(), sbe_pkg::slot_t'(n));
                queue_instr(sbe_pkg::OP_LOAD, pick_value(), sbe_pkg::slot_t'(n));
                queue_instr(sbe_pkg::OP_EMIT, pick_value(), pick_slot());
            end
            else if (kind < 80)
            begin
                // Fill the stack past the top, then empty it past the bottom.
                while (plan_depth < STACK_ENTRIES)
                    queue_operand();
                repeat ($urandom_range(1, 3))
                    queue_operand();
                while (plan_depth > 0)
                    queue_instr($urandom_range(0, 3) ? sbe_pkg::OP_EMIT : sbe_pkg::OP_SAVE,
                                pick_value(), pick_slot());
                repeat ($urandom_range(1, 2))
                    queue_instr($urandom_range(0, 1) ? pick_binary_op() : sbe_pkg::OP_EMIT,
                                pick_value(), pick_slot());
            end
            else
            begin
                // Noise: any opcode but halt, with random fields.
                repeat ($urandom_range(1, 4))
                    queue_instr(pick_live_op(), sbe_pkg::imm_t'($urandom()), pick_slot());
            end
        end
    endtask

    task automatic wait_program_done();
        while (program_queue.size() != 0 || instr_ch.valid)
            @(posedge clk);
    endtask

    // Shadow execution of one accepted instruction.
    function automatic result_item_t execute_instr(instr_item_t it);
        result_item_t r;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  res;
        logic [63:0]  wide;
        longint       sa;
        longint       sb;
        r.status      = sbe_pkg::ST_OK;
        r.print_value = '0;
        if (shadow_halted)
            r.status = sbe_pkg::ST_IGNORED;
        else
        begin
            case (it.op)
                sbe_pkg::OP_PUSH, sbe_pkg::OP_LOAD:
                    if (shadow_depth >= STACK_ENTRIES)
                        r.status = sbe_pkg::ST_OVERFLOW;
                    else
                    begin
                        shadow_stack[shadow_depth] = (it.op == sbe_pkg::OP_PUSH) ?
                            it.immediate : shadow_vars[it.slot % VAR_ENTRIES];
                        shadow_depth++;
                    end
                sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV:
                    if (shadow_depth < 2)
                        r.status = sbe_pkg::ST_UNDERFLOW;
                    else
                    begin
                        a  = shadow_stack[shadow_depth - 2];
                        b  = shadow_stack[shadow_depth - 1];
                        sa = $signed(a);
                        sb = $signed(b);
                        if (it.op == sbe_pkg::OP_DIV && b == '0)
                            r.status = sbe_pkg::ST_DIV_ZERO;
                        else
                        begin
                            // Products and quotients are formed at 64 bits and wrapped.
                            case (it.op)
                                sbe_pkg::OP_ADD: res = a + b;
                                sbe_pkg::OP_SUB: res = a - b;
                                sbe_pkg::OP_MUL:
                                begin
                                    wide = sa * sb;
                                    res  = wide[31:0];
                                end
                                default:
                                begin
                                    wide = sa / sb;
                                    res  = wide[31:0];
                                end
                            endcase
                            shadow_stack[shadow_depth - 2] = res;
                            shadow_depth--;
                        end
                    end
                sbe_pkg::OP_SAVE, sbe_pkg::OP_EMIT:
                    if (shadow_depth < 1)
                        r.status = sbe_pkg::ST_UNDERFLOW;
                    else
                    begin
                        shadow_depth--;
                        if (it.op == sbe_pkg::OP_SAVE)
                            shadow_vars[it.slot % VAR_ENTRIES] = shadow_stack[shadow_depth];
                        else
                        begin
                            r.status      = sbe_pkg::ST_PRINTED;
                            r.print_value = shadow_stack[shadow_depth];
                        end
                    end
                sbe_pkg::OP_HALT:
                begin
                    r.status      = sbe_pkg::ST_HALTED;
                    shadow_halted = 1'b1;
                end
                default:
                    r.status = sbe_pkg::ST_UNKNOWN;
            endcase
        end
        r.stack_depth = sbe_pkg::depth_t'(shadow_depth);
        return r;
    endfunction

    // Instruction driver: holds an item until it is taken, then idles at random.
    always @(negedge clk)
    begin
        instr_item_t it;
        if (rst_n)
        begin
            if (instr_ch.valid && !instr_taken)
                ;
            else if (issue_gap > 0)
            begin
                instr_ch.valid <= 1'b0;
                issue_gap--;
            end
            else if (program_queue.size() != 0)
            begin
                it = program_queue.pop_front();
                instr_ch.op        <= it.op;
                instr_ch.immediate <= it.immediate;
                instr_ch.slot      <= it.slot;
                instr_ch.valid     <= 1'b1;
                issue_gap = pick_gap();
            end
            else
                instr_ch.valid <= 1'b0;
        end
    end

    // Result acceptor: random stalls on ready.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (accept_stall > 0)
            begin
                result_ch.ready <= 1'b0;
                accept_stall--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                accept_stall = pick_gap();
            end
        end
    end

    // Monitor: check results, predict accepted instructions, watch for hangs.
    always @(posedge clk)
    begin
        result_item_t want;
        instr_item_t  got;
        if (rst_n)
        begin
            instr_taken <= instr_ch.valid && instr_ch.ready;

            if (result_ch.valid && result_ch.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result item with no instruction outstanding");
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result_ch.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, result_ch.status);
                        error_count++;
                    end
                    if (result_ch.print_value !== want.print_value)
                    begin
                        $error("print_value mismatch: expected %0d, actual %0d",
                               want.print_value, result_ch.print_value);
                        error_count++;
                    end
                    if (result_ch.stack_depth !== want.stack_depth)
                    begin
                        $error("stack_depth mismatch: expected %0d, actual %0d",
                               want.stack_depth, result_ch.stack_depth);
                        error_count++;
                    end
                end
            end

            if (instr_ch.valid && instr_ch.ready)
            begin
                got.op        = instr_ch.op;
                got.immediate = instr_ch.immediate;
                got.slot      = instr_ch.slot;
                predicted_results.push_back(execute_instr(got));
            end

            if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus and end of test.
    initial
    begin
        rst_n               = 1'b0;
        instr_ch.valid      = 1'b0;
        instr_ch.op         = sbe_pkg::OP_PUSH;
        instr_ch.immediate  = '0;
        instr_ch.slot       = '0;
        result_ch.ready     = 1'b0;
        instr_taken         = 1'b0;
        issue_gap           = 0;
        accept_stall        = 0;
        error_count         = 0;
        idle_cycles         = 0;
        quiet_phase         = 1'b0;
        plan_depth          = 0;
        shadow_depth        = 0;
        shadow_halted       = 1'b0;
        for (int i = 0; i < VAR_ENTRIES; i++)
            shadow_vars[i] = '0;
        for (int i = 0; i < STACK_ENTRIES; i++)
            shadow_stack[i] = '0;

        // Directed: errors on an empty stack and unknown opcodes.
        queue_instr(sbe_pkg::OP_EMIT, '0, '0);
        queue_instr(sbe_pkg::OP_SAVE, '0, '0);
        queue_instr(sbe_pkg::OP_ADD, '0, '0);
        queue_instr(OP_FIRST_UNUSED, 32'h7fff_ffff, 6'd63);
        queue_instr(OP_LAST_UNUSED, 32'h8000_0000, 6'd63);
        // A never-written slot loads as zero; div with one entry underflows.
        queue_instr(sbe_pkg::OP_LOAD, sbe_pkg::imm_t'(-1), 6'd63);
        queue_instr(sbe_pkg::OP_DIV, '0, '0);
        // Most negative divided by minus one wraps.
        queue_instr(sbe_pkg::OP_PUSH, 32'h8000_0000, '0);
        queue_instr(sbe_pkg::OP_PUSH, sbe_pkg::imm_t'(-1), '0);
        queue_instr(sbe_pkg::OP_DIV, '0, '0);
        queue_instr(sbe_pkg::OP_EMIT, '0, '0);
        // Add wraps at the top; the sum goes to slot zero.
        queue_instr(sbe_pkg::OP_PUSH, 32'h7fff_ffff, '0);
        queue_instr(sbe_pkg::OP_PUSH, sbe_pkg::imm_t'(1), '0);
        queue_instr(sbe_pkg::OP_ADD, '0, '0);
        queue_instr(sbe_pkg::OP_SAVE, '0, 6'd0);
        // Divide by zero leaves both operands in place.
        queue_instr(sbe_pkg::OP_PUSH, 32'h7fff_ffff, '0);
        queue_instr(sbe_pkg::OP_PUSH, '0, '0);
        queue_instr(sbe_pkg::OP_DIV, '0, '0);
        queue_instr(sbe_pkg::OP_SUB, '0, '0);
        queue_instr(sbe_pkg::OP_PUSH, 32'h7fff_ffff, '0);
        queue_instr(sbe_pkg::OP_MUL, '0, '0);
        queue_instr(sbe_pkg::OP_EMIT, '0, '0);
        queue_instr(sbe_pkg::OP_LOAD, '0, 6'd0);
        queue_instr(sbe_pkg::OP_EMIT, '0, '0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_program_done();

        queue_random_phase(PHASE_ITEMS);
        wait_program_done();

        quiet_phase = 1'b1;
        queue_random_phase(PHASE_ITEMS);
        wait_program_done();

        quiet_phase = 1'b0;
        queue_random_phase(PHASE_ITEMS);

        // Halt, then items that must all be ignored.
        queue_instr(sbe_pkg::OP_HALT, pick_value(), pick_slot());
        queue_instr(sbe_pkg::OP_PUSH, pick_value(), pick_slot());
        queue_instr(sbe_pkg::OP_EMIT, pick_value(), pick_slot());
        queue_instr(sbe_pkg::OP_HALT, pick_value(), pick_slot());
        queue_instr(OP_LAST_UNUSED, pick_value(), pick_slot());
        repeat (4)
            queue_instr(pick_live_op(), sbe_pkg::imm_t'($urandom()), pick_slot());
        wait_program_done();

        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: stack_bytecode_executor.f
rtl/sbe_pkg.sv
rtl/sbe_if.sv
rtl/sbe_ram.sv
rtl/sbe_muldiv.sv
rtl/sbe_datapath.sv
rtl/sbe_ctrl.sv
rtl/stack_bytecode_executor.sv
sim/tb_stack_bytecode_executor.sv
